/* rtl/kmld_pkg.sv */
// ----------------------------------------------------------------------------
// kmld_pkg
// Shared types and constants for the key matrix lockout debounce block.
// ----------------------------------------------------------------------------
package kmld_pkg;

    localparam int ROWS = 8;
    localparam int COLS = 16;

    localparam int ROW_W    = 3;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 8;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;

    // Columns that really exist: below both COLS and the field width.
    localparam int LIVE_COLS = (COLS < SAMPLE_W) ? COLS : SAMPLE_W;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               pressed;
    } t_key_state;

    typedef t_key_state [COLS-1:0] t_row_state;

    localparam int ROW_STATE_W = $bits(t_row_state);

endpackage

/* rtl/kmld_row_ram.sv */
// ----------------------------------------------------------------------------
// kmld_row_ram
// Single-port-write, single-port-read synchronous RAM with registered read
// data. The read register updates only when a read is requested.
// ----------------------------------------------------------------------------
module kmld_row_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/kmld_row_update.sv */
// ----------------------------------------------------------------------------
// kmld_row_update
// Per-key debounce update for one row: every column is handled in parallel.
// ----------------------------------------------------------------------------
module kmld_row_update import kmld_pkg::*; (
    input  t_row_state          i_state,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [COUNT_W-1:0]  i_debounce_time,
    output t_row_state          o_state,
    output logic [SAMPLE_W-1:0] o_pressed_bits,
    output logic [SAMPLE_W-1:0] o_changed_bits
);

    always_comb begin
        o_state        = i_state;
        o_pressed_bits = '0;
        o_changed_bits = '0;
        for (int c = 0; c < LIVE_COLS; c++) begin
            if (i_state[c].count == '0) begin
                if (i_sample[c] != i_state[c].pressed) begin
                    o_state[c].count  = i_debounce_time;
                    o_changed_bits[c] = 1'b1;
                end
                o_state[c].pressed = i_sample[c];
            end else begin
                o_state[c].count = i_state[c].count - 1'b1;
            end
            o_pressed_bits[c] = o_state[c].pressed;
        end
    end

endmodule

/* rtl/key_matrix_lockout_debounce.sv */
// ----------------------------------------------------------------------------
// key_matrix_lockout_debounce
// Key matrix scanner with eager (lockout) debouncing over a row-indexed RAM.
// ----------------------------------------------------------------------------
// The block accepts one row sample every clock cycle while the output is not
// stalled and returns one result per sample. Each sample passes through the
// RAM stage register and then the output register, which holds the result
// until it is taken. Per-key state (pressed bit and lockout counter) lives in
// a row-wide RAM, read in the acceptance cycle and written back when the
// transaction leaves the RAM stage. The single read port sets the rate of one
// row per cycle. When the output is stalled, the RAM stage and the output
// register hold two transactions and the input waits until the output
// register is taken. Back-to-back samples of the same row are served by
// forwarding the written row. Rows never written since reset read as all keys
// released and unlocked, so no clearing pass is needed. The debounce time
// register resets to 5 and should be written only while the block is idle.
module key_matrix_lockout_debounce import kmld_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ROW_W-1:0]    i_row_index,
    input  logic [SAMPLE_W-1:0] i_column_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_pressed_bits,
    output logic [SAMPLE_W-1:0] o_changed_bits
);

    localparam int ADDR_W = $clog2(ROWS);

    logic [COUNT_W-1:0]  r_debounce_time;

    logic                r_s1_valid;
    logic [ADDR_W-1:0]   r_s1_row;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_row_valid;
    logic                r_fwd;
    t_row_state          r_fwd_state;
    logic [ROWS-1:0]     r_row_valid;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_pressed_bits;
    logic [SAMPLE_W-1:0] r_changed_bits;

    logic                in_fire;
    logic                s1_fire;
    logic [ADDR_W-1:0]   in_row;
    logic [ROW_STATE_W-1:0] ram_q;
    t_row_state          s1_state;
    t_row_state          new_state;
    logic [SAMPLE_W-1:0] new_pressed;
    logic [SAMPLE_W-1:0] new_changed;

    assign in_row      = i_row_index[ADDR_W-1:0];
    assign s1_fire     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    kmld_row_ram #(
        .WIDTH (ROW_STATE_W),
        .DEPTH (ROWS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_row),
        .o_rd_data (ram_q),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_row),
        .i_wr_data (new_state)
    );

    // The forwarded row wins over the RAM, which may still hold stale data.
    always_comb begin
        if (r_fwd) begin
            s1_state = r_fwd_state;
        end else if (r_s1_row_valid) begin
            s1_state = t_row_state'(ram_q);
        end else begin
            s1_state = '0;
        end
    end

    kmld_row_update u_row_update (
        .i_state         (s1_state),
        .i_sample        (r_s1_sample),
        .i_debounce_time (r_debounce_time),
        .o_state         (new_state),
        .o_pressed_bits  (new_pressed),
        .o_changed_bits  (new_changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_debounce_time <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_fire && (in_row == r_s1_row);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (s1_fire) begin
                r_row_valid[r_s1_row] <= 1'b1;
                r_out_valid           <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_row       <= in_row;
            r_s1_sample    <= i_column_sample;
            r_s1_row_valid <= r_row_valid[in_row];
            r_fwd_state    <= new_state;
        end
        if (s1_fire) begin
            r_pressed_bits <= new_pressed;
            r_changed_bits <= new_changed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pressed_bits = r_pressed_bits;
    assign o_changed_bits = r_changed_bits;

    // Forwarding is only meaningful for a transaction held in the RAM stage.
    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set without an item in the RAM stage");

    // A transaction leaving the RAM stage always lands in the output register.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("result lost between RAM stage and output register");

    // An empty RAM stage never blocks the input channel.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_in_ready)
        else $error("input stalled while the RAM stage is empty");

    // A key reported as changed was written back into its row.
    a_change_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (new_changed != '0)) |=> r_row_valid[$past(r_s1_row)])
        else $error("changed row not marked valid");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for key_matrix_lockout_debounce. Row samples are
// driven through the input channel, and each accepted transaction is run
// through a per-key lockout debounce predictor. Every result transaction is
// compared field by field with the oldest prediction. Directed scans cover
// the reset debounce time, zero and maximum debounce times and the extreme
// rows and columns. Random scans then model held keys with contact bounce
// under several debounce settings, with random idling on both channels, a
// long output stall and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import kmld_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pressed;
        logic [SAMPLE_W-1:0] changed;
    } t_scan_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ROW_W-1:0]    i_row_index;
    logic [SAMPLE_W-1:0] i_column_sample;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [SAMPLE_W-1:0] o_pressed_bits;
    logic [SAMPLE_W-1:0] o_changed_bits;

    // Debounce predictor state.
    logic [COUNT_W-1:0]  lock_left [ROWS][COLS];
    logic [COLS-1:0]     debounced [ROWS];
    logic [COUNT_W-1:0]  debounce_setting;

    // Levels of the simulated physical keys, used to build bouncy samples.
    logic [SAMPLE_W-1:0] key_level [ROWS];
    logic [ROW_W-1:0]    last_row;

    t_scan_result        pending_scans[$];

    int  mismatches;
    int  scans_sent;
    int  scans_checked;
    int  cfg_writes;
    int  cycle_count;
    int  hold_cycles;
    bit  in_idle_on;
    bit  out_idle_on;

    key_matrix_lockout_debounce dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_row_index     (i_row_index),
        .i_column_sample (i_column_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pressed_bits  (o_pressed_bits),
        .o_changed_bits  (o_changed_bits)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results still pending",
                     $realtime, pending_scans.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Per-key lockout debounce of one row scan.
    task automatic debounce_row(input logic [ROW_W-1:0] row,
                                input logic [SAMPLE_W-1:0] sample,
                                output t_scan_result res);
        int r;
        res = '0;
        r = int'(row);
        if (r < ROWS) begin
            for (int c = 0; c < LIVE_COLS; c++) begin
                if (lock_left[r][c] == '0) begin
                    if (sample[c] != debounced[r][c]) begin
                        lock_left[r][c] = debounce_setting;
                        res.changed[c] = 1'b1;
                    end
                    debounced[r][c] = sample[c];
                end else begin
                    lock_left[r][c] = lock_left[r][c] - 1'b1;
                end
                res.pressed[c] = debounced[r][c];
            end
        end
    endtask

    task automatic send_scan(input logic [ROW_W-1:0] row,
                             input logic [SAMPLE_W-1:0] sample);
        t_scan_result res;
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_row_index     <= row;
        i_column_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        debounce_row(row, sample, res);
        pending_scans.push_back(res);
        scans_sent++;
        last_row = row;
    endtask

    task automatic maybe_pause();
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 9)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [COUNT_W-1:0] value);
        wait_drained();
        // Let the pipeline empty fully before touching the register.
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        debounce_setting = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly held keys with sparse bounce; now and then a fully random sample.
    task automatic send_bouncy_scan();
        logic [ROW_W-1:0]    row;
        logic [SAMPLE_W-1:0] sample;
        row = ($urandom_range(0, 9) < 3) ? last_row : ROW_W'($urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 9) == 0) begin
            sample = SAMPLE_W'($urandom);
        end else begin
            if ($urandom_range(0, 5) == 0)
                key_level[row] ^= SAMPLE_W'($urandom & $urandom & $urandom);
            sample = key_level[row];
            if ($urandom_range(0, 2) == 0)
                sample ^= SAMPLE_W'($urandom & $urandom & $urandom);
        end
        send_scan(row, sample);
    endtask

    // Output side: random stall bursts, or a long counted hold when requested.
    initial begin : receiver
        int  burst;
        bit  ready_next;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                ready_next = 1'b0;
            end else begin
                if (out_idle_on && burst == 0 && $urandom_range(0, 5) == 0)
                    burst = $urandom_range(1, 9);
                if (burst > 0) begin
                    burst--;
                    ready_next = 1'b0;
                end else begin
                    ready_next = 1'b1;
                end
            end
            i_out_ready <= ready_next;
        end
    end

    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_scans.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual pressed=%h changed=%h",
                         $realtime, o_pressed_bits, o_changed_bits);
            end else begin
                want = pending_scans.pop_front();
                scans_checked++;
                if (o_pressed_bits !== want.pressed) begin
                    mismatches++;
                    $display("%0t: pressed_bits expected %h actual %h",
                             $realtime, want.pressed, o_pressed_bits);
                end
                if (o_changed_bits !== want.changed) begin
                    mismatches++;
                    $display("%0t: changed_bits expected %h actual %h",
                             $realtime, want.changed, o_changed_bits);
                end
            end
        end
    end

    task automatic test_default_lockout();
        // Reset debounce time: six releases in a row, the sixth one unlocks.
        send_scan(3'd0, 16'hFFFF);
        repeat (6) send_scan(3'd0, 16'h0000);
        send_scan(3'd7, 16'h8001);
        maybe_pause();
        send_scan(3'd7, 16'h7FFE);
        maybe_pause();
    endtask

    task automatic test_zero_debounce();
        write_debounce(8'd0);
        send_scan(3'd3, 16'hAAAA);
        send_scan(3'd3, 16'h5555);
        send_scan(3'd3, 16'hAAAA);
        send_scan(3'd3, 16'h0000);
        maybe_pause();
        send_scan(3'd3, 16'hFFFF);
        send_scan(3'd7, 16'hFFFF);
        send_scan(3'd0, 16'h0000);
        maybe_pause();
    endtask

    task automatic test_max_debounce();
        write_debounce(8'hFF);
        send_scan(3'd5, 16'hFFFF);
        send_scan(3'd5, 16'h0000);
        send_scan(3'd5, 16'h0000);
        write_debounce(8'd1);
        send_scan(3'd2, 16'hFFFF);
        send_scan(3'd2, 16'h0000);
        send_scan(3'd2, 16'h0000);
        send_scan(3'd2, 16'hFFFF);
        maybe_pause();
    endtask

    task automatic test_random_settings();
        logic [COUNT_W-1:0] settings [6];
        settings = '{8'd1, 8'd3, 8'd0, 8'hFF, 8'd2, COUNT_W'($urandom)};
        foreach (settings[i]) begin
            write_debounce(settings[i]);
            repeat (150) begin
                send_bouncy_scan();
                maybe_pause();
            end
        end
    endtask

    task automatic test_backpressure();
        write_debounce(8'd4);
        in_idle_on  = 1'b0;
        hold_cycles = 100;
        repeat (40) send_bouncy_scan();
        wait_drained();
        in_idle_on = 1'b1;
        repeat (20) begin
            send_bouncy_scan();
            maybe_pause();
        end
    endtask

    task automatic test_full_rate_tail();
        write_debounce(COUNT_W'($urandom_range(1, 6)));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (90) send_bouncy_scan();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_row_index     = '0;
        i_column_sample = '0;
        i_out_ready     = 1'b0;
        mismatches      = 0;
        scans_sent      = 0;
        scans_checked   = 0;
        cfg_writes      = 0;
        cycle_count     = 0;
        hold_cycles     = 0;
        in_idle_on      = 1'b1;
        out_idle_on     = 1'b1;
        last_row        = '0;
        debounce_setting = DEBOUNCE_RESET;
        for (int r = 0; r < ROWS; r++) begin
            debounced[r] = '0;
            key_level[r] = '0;
            for (int c = 0; c < COLS; c++) lock_left[r][c] = '0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_lockout();
        test_zero_debounce();
        test_max_debounce();
        test_random_settings();
        test_backpressure();
        test_full_rate_tail();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d row scans over %0d debounce time writes,",
                 scans_checked, scans_sent, cfg_writes);
        $display("with bouncing keys, random stalls and a long output hold.");
        if (mismatches == 0 && pending_scans.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/kmld_pkg.sv
rtl/kmld_row_ram.sv
rtl/kmld_row_update.sv
rtl/key_matrix_lockout_debounce.sv
sim/tb_top.sv
